// ===== src/m68k_line0_immediate_bit_alu_top_defines.svh =====
// Assertion macros for the line-0 execute block checker.
// Used by m68kl0_checker; depends on nothing else.
`ifndef M68K_LINE0_IMMEDIATE_BIT_ALU_TOP_DEFINES_SVH
`define M68K_LINE0_IMMEDIATE_BIT_ALU_TOP_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define M68KL0_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("m68kl0 check failed");

// Implication whose consequent is checked in the following cycle.
`define M68KL0_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m68kl0 check failed");

`endif

// ===== src/m68kl0_pkg.sv =====
// Shared types, opcode codes and helpers of the line-0 execute block.
// No dependencies; imported by the front end, back end and top level.
`timescale 1ns / 1ps

package m68kl0_pkg;

  // High byte codes of the immediate ALU group
  localparam logic [7:0] HI_ORI  = 8'h00;
  localparam logic [7:0] HI_ANDI = 8'h02;
  localparam logic [7:0] HI_SUBI = 8'h04;
  localparam logic [7:0] HI_ADDI = 8'h06;
  localparam logic [7:0] HI_BITS = 8'h08;
  localparam logic [7:0] HI_EORI = 8'h0A;
  localparam logic [7:0] HI_CMPI = 8'h0C;

  // Low byte codes selecting the CCR and SR destinations
  localparam logic [7:0] LO_CCR = 8'h3C;
  localparam logic [7:0] LO_SR  = 8'h7C;

  localparam logic [2:0] MODE_DN   = 3'd0;
  localparam logic [2:0] MODE_AN   = 3'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [1:0] BIT_TST = 2'd0;
  localparam logic [1:0] BIT_CHG = 2'd1;
  localparam logic [1:0] BIT_CLR = 2'd2;
  localparam logic [1:0] BIT_SET = 2'd3;

  localparam int SUPER_POS = 13;
  localparam logic [15:0] SR_RESET = 16'h2000;

  // Operation classes assigned by the front end
  localparam logic [3:0] CLS_ILL     = 4'd0;
  localparam logic [3:0] CLS_CCR_OR  = 4'd1;
  localparam logic [3:0] CLS_CCR_AND = 4'd2;
  localparam logic [3:0] CLS_CCR_EOR = 4'd3;
  localparam logic [3:0] CLS_SR_OR   = 4'd4;
  localparam logic [3:0] CLS_SR_AND  = 4'd5;
  localparam logic [3:0] CLS_SUB     = 4'd6;
  localparam logic [3:0] CLS_CMP     = 4'd7;
  localparam logic [3:0] CLS_ADD     = 4'd8;
  localparam logic [3:0] CLS_OR      = 4'd9;
  localparam logic [3:0] CLS_AND     = 4'd10;
  localparam logic [3:0] CLS_EOR     = 4'd11;
  localparam logic [3:0] CLS_MOVEP   = 4'd12;
  localparam logic [3:0] CLS_BIT     = 4'd13;

  typedef struct packed {
    logic [3:0]  cls;
    logic [1:0]  size;
    logic [4:0]  bitno;
    logic [31:0] src;
    logic [31:0] dst;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        wb;
    logic        ill;
    logic        priv;
    logic        unh;
    logic [15:0] status;
  } res_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SIZE_BYTE: size_mask = 32'h0000_00FF;
      SIZE_WORD: size_mask = 32'h0000_FFFF;
      default:   size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

// ===== src/m68kl0_front.sv =====
// Front end: decodes and classifies opcode words into a two-entry queue.
// Depends on m68kl0_pkg.
`timescale 1ns / 1ps

module m68kl0_front import m68kl0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] opcode_word,
  input  logic [31:0] immediate_value,
  input  logic [31:0] dest_operand,
  output logic        head_valid,
  output item_t       head,
  input  logic        take
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic       in_fire;
  logic       out_fire;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [1:0] sz;
  logic [2:0] mode;
  logic       is_log;
  logic       is_alu;

  assign hi   = opcode_word[15:8];
  assign lo   = opcode_word[7:0];
  assign sz   = lo[7:6];
  assign mode = lo[5:3];
  assign is_log = (hi == HI_ORI) || (hi == HI_ANDI) || (hi == HI_EORI);
  assign is_alu = is_log || (hi == HI_SUBI) || (hi == HI_ADDI) || (hi == HI_CMPI);

  always_comb begin
    dec.cls   = CLS_ILL;
    dec.size  = sz;
    dec.bitno = immediate_value[4:0];
    dec.src   = immediate_value & size_mask(sz);
    dec.dst   = dest_operand & size_mask(sz);
    if (hi[7:4] != 4'd0) begin
      dec.cls = CLS_ILL;
    end else if (is_log && lo == LO_CCR) begin
      dec.src = {27'd0, immediate_value[4:0]};
      if (hi == HI_ORI) begin
        dec.cls = CLS_CCR_OR;
      end else if (hi == HI_ANDI) begin
        // keep the upper status bits through the AND
        dec.cls = CLS_CCR_AND;
        dec.src = {27'h7FF_FFFF, immediate_value[4:0]};
      end else begin
        dec.cls = CLS_CCR_EOR;
      end
    end else if (is_log && lo == LO_SR) begin
      dec.src = {16'd0, immediate_value[15:0]};
      if (hi == HI_EORI) dec.cls = CLS_ILL;
      else if (hi == HI_ORI) dec.cls = CLS_SR_OR;
      else dec.cls = CLS_SR_AND;
    end else if (is_alu) begin
      if (sz == SIZE_BAD) dec.cls = CLS_ILL;
      else begin
        case (hi)
          HI_ORI:  dec.cls = CLS_OR;
          HI_ANDI: dec.cls = CLS_AND;
          HI_EORI: dec.cls = CLS_EOR;
          HI_SUBI: dec.cls = CLS_SUB;
          HI_ADDI: dec.cls = CLS_ADD;
          default: dec.cls = CLS_CMP;
        endcase
      end
    end else if (hi != HI_BITS && mode == MODE_AN) begin
      dec.cls = CLS_MOVEP;
    end else begin
      dec.cls = CLS_BIT;
      if (mode == MODE_DN) begin
        dec.dst = dest_operand;
      end else begin
        dec.bitno = {2'd0, immediate_value[2:0]};
        dec.dst   = {24'd0, dest_operand[7:0]};
      end
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];
  assign in_fire    = push && !full;
  assign out_fire   = take && head_valid;

  always_ff @(posedge clk) begin
    if (in_fire) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_fire) wr_ptr <= !wr_ptr;
      if (out_fire) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

endmodule

// ===== src/m68kl0_back.sv =====
// Back end: executes classified items, keeps the status register and
// buffers results in a two-entry queue. Depends on m68kl0_pkg.
`timescale 1ns / 1ps

module m68kl0_back import m68kl0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head,
  output logic        take,
  output logic        empty,
  input  logic        pop,
  output res_t        res_head
);

  logic [15:0] sr;
  logic [15:0] sr_next;
  res_t        rq [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  res_t        res;
  logic [32:0] diff;
  logic [32:0] sum;
  logic [31:0] mask;
  logic [31:0] r;
  logic [31:0] bitsel;
  logic        n_flag;
  logic        z_flag;
  logic        v_flag;
  logic        c_flag;
  logic        out_fire;

  function automatic logic msb_of(input logic [31:0] v, input logic [1:0] sz);
    case (sz)
      SIZE_BYTE: msb_of = v[7];
      SIZE_WORD: msb_of = v[15];
      default:   msb_of = v[31];
    endcase
  endfunction

  assign mask   = size_mask(head.size);
  assign diff   = {1'b0, head.dst} - {1'b0, head.src};
  assign sum    = {1'b0, head.dst} + {1'b0, head.src};
  assign bitsel = 32'd1 << head.bitno;

  always_comb begin
    sr_next = sr;
    r       = 32'd0;
    n_flag  = 1'b0;
    z_flag  = 1'b0;
    v_flag  = 1'b0;
    c_flag  = 1'b0;
    res.wb   = 1'b0;
    res.ill  = 1'b0;
    res.priv = 1'b0;
    res.unh  = 1'b0;
    case (head.cls)
      CLS_CCR_OR:  sr_next = sr | head.src[15:0];
      CLS_CCR_AND: sr_next = sr & head.src[15:0];
      CLS_CCR_EOR: sr_next = sr ^ head.src[15:0];
      CLS_SR_OR: begin
        if (!sr[SUPER_POS]) res.priv = 1'b1;
        else sr_next = sr | head.src[15:0];
      end
      CLS_SR_AND: begin
        if (!sr[SUPER_POS]) res.priv = 1'b1;
        else sr_next = sr & head.src[15:0];
      end
      CLS_SUB, CLS_CMP: begin
        r      = diff[31:0] & mask;
        n_flag = msb_of(r, head.size);
        z_flag = (r == 32'd0);
        v_flag = msb_of((head.src ^ head.dst) & (head.dst ^ r), head.size);
        c_flag = diff[32];
        if (head.cls == CLS_SUB) begin
          sr_next = {sr[15:5], c_flag, n_flag, z_flag, v_flag, c_flag};
          res.wb  = 1'b1;
        end else begin
          sr_next = {sr[15:4], n_flag, z_flag, v_flag, c_flag};
          r       = 32'd0;
        end
      end
      CLS_ADD: begin
        r      = sum[31:0] & mask;
        n_flag = msb_of(r, head.size);
        z_flag = (r == 32'd0);
        v_flag = msb_of((head.src ^ r) & (head.dst ^ r), head.size);
        case (head.size)
          SIZE_BYTE: c_flag = sum[8];
          SIZE_WORD: c_flag = sum[16];
          default:   c_flag = sum[32];
        endcase
        sr_next = {sr[15:5], c_flag, n_flag, z_flag, v_flag, c_flag};
        res.wb  = 1'b1;
      end
      CLS_OR, CLS_AND, CLS_EOR: begin
        if (head.cls == CLS_OR) r = head.dst | head.src;
        else if (head.cls == CLS_AND) r = head.dst & head.src;
        else r = head.dst ^ head.src;
        n_flag  = msb_of(r, head.size);
        z_flag  = (r == 32'd0);
        sr_next = {sr[15:4], n_flag, z_flag, 2'b00};
        res.wb  = 1'b1;
      end
      CLS_MOVEP: res.unh = 1'b1;
      CLS_BIT: begin
        sr_next[2] = ((head.dst & bitsel) == 32'd0);
        case (head.size)
          BIT_CHG: r = head.dst ^ bitsel;
          BIT_CLR: r = head.dst & ~bitsel;
          BIT_SET: r = head.dst | bitsel;
          default: r = 32'd0;
        endcase
        res.wb = (head.size != BIT_TST);
      end
      default: res.ill = 1'b1;
    endcase
    res.value  = r;
    res.status = sr_next;
  end

  // advance only while the result queue has room
  assign take     = head_valid && (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign res_head = rq[rd_ptr];
  assign out_fire = pop && !empty;

  always_ff @(posedge clk) begin
    if (take) rq[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sr     <= SR_RESET;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        sr     <= sr_next;
        wr_ptr <= !wr_ptr;
      end
      if (out_fire) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, take} - {1'b0, out_fire};
    end
  end

endmodule

// ===== src/m68k_line0_immediate_bit_alu_top.sv =====
// Line-0 immediate and bit instruction execute block.
// Flow: a beat accepted into the front queue is executed from its head and
// registered into the result queue, where it can be popped, once that queue has room.
// Throughput: one item per cycle while the result queue has room; the execute step
// with its status register feedback sets that rate. Two-entry queues on each side.
// Reset (rst, synchronous): status register 0x2000, both queues empty.
`timescale 1ns / 1ps

module m68k_line0_immediate_bit_alu_top import m68kl0_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] opcode_word,
  input  logic [31:0] immediate_value,
  input  logic [31:0] dest_operand,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] result_value,
  output logic        write_back,
  output logic        illegal,
  output logic        privilege_fault,
  output logic        unhandled,
  output logic [15:0] status_out
);

  item_t head;
  logic  head_valid;
  logic  take;
  res_t  res_head;

  m68kl0_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .opcode_word     (opcode_word),
    .immediate_value (immediate_value),
    .dest_operand    (dest_operand),
    .head_valid      (head_valid),
    .head            (head),
    .take            (take)
  );

  m68kl0_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .res_head   (res_head)
  );

  assign result_value    = res_head.value;
  assign write_back      = res_head.wb;
  assign illegal         = res_head.ill;
  assign privilege_fault = res_head.priv;
  assign unhandled       = res_head.unh;
  assign status_out      = res_head.status;

endmodule

// ===== src/m68kl0_checker.sv =====
// Port-level checks of the line-0 execute block, bound to the top level.
// Depends on m68k_line0_immediate_bit_alu_top_defines.svh.
`timescale 1ns / 1ps
`include "m68k_line0_immediate_bit_alu_top_defines.svh"

module m68kl0_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] result_value,
  input logic        write_back,
  input logic        illegal,
  input logic        privilege_fault,
  input logic        unhandled,
  input logic [15:0] status_out
);

  // no stored value without write-back
  `M68KL0_ASSERT_NOW(a_zero_no_wb, empty || write_back || result_value == 32'd0)
  // at most one outcome per result beat
  `M68KL0_ASSERT_NOW(a_one_outcome,
      empty || $countones({write_back, illegal, privilege_fault, unhandled}) <= 1)
  // a privilege fault only happens in user mode, and the fault keeps SR
  `M68KL0_ASSERT_NOW(a_priv_user, empty || !privilege_fault || !status_out[13])
  // a waiting result holds its status
  `M68KL0_ASSERT_NEXT(a_hold_status, !empty && !pop, !empty && $stable(status_out))

endmodule

bind m68k_line0_immediate_bit_alu_top m68kl0_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .result_value    (result_value),
  .write_back      (write_back),
  .illegal         (illegal),
  .privilege_fault (privilege_fault),
  .unhandled       (unhandled),
  .status_out      (status_out)
);
